// ===== rtl/core/qedd_pkg.sv =====
// Shared types and constants for the quadrature encoder detent decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package qedd_pkg;

  // Fixed geometry of the block
  localparam int ENC_SLOTS   = 4;
  localparam int IDX_W       = 2;
  localparam int DIV_W       = 8;
  localparam int ACC_W       = 9;
  localparam int SUM_W       = ACC_W + 1;

  localparam logic [DIV_W-1:0] DIV_RESET = 8'd4;
  localparam logic [DIV_W-1:0] DIV_MIN   = 8'd1;

  // Tap direction codes
  localparam logic DIR_POS = 1'b0;
  localparam logic DIR_NEG = 1'b1;

  // One sample of an encoder
  typedef struct packed {
    logic [IDX_W-1:0] encoder_index;
    logic             chan_a;
    logic             chan_b;
  } in_t;

  // One emitted tap
  typedef struct packed {
    logic [IDX_W-1:0] tap_encoder;
    logic             tap_direction;
  } out_t;

  // Per-encoder decode result handed from the step logic to the top level
  typedef struct packed {
    logic                    emit;
    logic                    dir;
    logic signed [ACC_W-1:0] accum_next;
  } step_res_t;

  // Quadrature step table, indexed by {previous phase, current phase}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/qedd_cfg.sv =====
// Divider registers for the detent decoder, with clamping to a minimum of one.
// Depends on qedd_pkg.
`timescale 1ns / 1ps

module qedd_cfg
  import qedd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0] cfg_data,
  input  logic [IDX_W-1:0] sel,
  output logic [DIV_W-1:0] divider
);

  logic [DIV_W-1:0] div_reg [ENC_SLOTS];
  logic [DIV_W-1:0] div_raw;

  // Register file, one divider per encoder
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENC_SLOTS; k++) begin
        div_reg[k] <= DIV_RESET;
      end
    end else if (cfg_we) begin
      div_reg[cfg_index] <= cfg_data;
    end
  end

  // A zero divider behaves as one
  assign div_raw = div_reg[sel];
  assign divider = (div_raw == '0) ? DIV_MIN : div_raw;

endmodule

// ===== rtl/core/qedd_step.sv =====
// Combinational decode of one sample: table step, reversal clear, divider test.
// Depends on qedd_pkg.
`timescale 1ns / 1ps

module qedd_step
  import qedd_pkg::*;
(
  input  logic                    seen,
  input  logic [1:0]              last_phase,
  input  logic [1:0]              cur_phase,
  input  logic signed [ACC_W-1:0] accum,
  input  logic [DIV_W-1:0]        divider,
  output step_res_t               res
);

  logic signed [1:0]       st;
  logic signed [SUM_W-1:0] acc_x;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] d;
  logic signed [SUM_W-1:0] nd;
  logic signed [SUM_W-1:0] rem_pos;
  logic signed [SUM_W-1:0] rem_neg;
  logic signed [SUM_W-1:0] acc_out;
  logic                    reversal;

  assign st = quad_step({last_phase, cur_phase});
  assign d  = $signed({2'b00, divider});
  assign nd = -d;

  // Direction reversal drops any pending steps
  assign reversal = (st > 0 && accum < 0) || (st < 0 && accum > 0);
  assign acc_x    = reversal ? '0 : {accum[ACC_W-1], accum};
  assign sum      = acc_x + {{(SUM_W-2){st[1]}}, st};

  assign rem_pos = sum - d;
  assign rem_neg = sum + d;

  // Threshold test; excess beyond one tap is clamped away
  always_comb begin
    res.emit = 1'b0;
    res.dir  = DIR_POS;
    acc_out  = sum;
    if (sum >= d) begin
      res.emit = 1'b1;
      res.dir  = DIR_POS;
      acc_out  = (rem_pos >= d) ? d - $signed(SUM_W'(1)) : rem_pos;
    end else if (sum <= nd) begin
      res.emit = 1'b1;
      res.dir  = DIR_NEG;
      acc_out  = (rem_neg <= nd) ? $signed(SUM_W'(1)) - d : rem_neg;
    end
    // First sample of an encoder only records the phase
    if (!seen) begin
      res.emit = 1'b0;
      acc_out  = '0;
    end
    res.accum_next = acc_out[ACC_W-1:0];
  end

endmodule

// ===== rtl/core/quadrature_encoder_detent_decoder.sv =====
// Top level of the quadrature encoder detent decoder: sample register,
// per-encoder state and tap output register. Depends on qedd_pkg, qedd_cfg, qedd_step.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    in_data   (in_t)
//   out       output      out_valid / out_stall  out_data  (out_t)
//   cfg       input       cfg_we                 cfg_index, cfg_data
//
// One sample per cycle while in_stall is low. A taken sample is held in the sample register,
// and the decode and state update then write the output register from it.
// Reset clears all encoder state and sets every divider to 4.
// in_stall rises only when a decoded tap waits behind a held output transaction.
`timescale 1ns / 1ps

module quadrature_encoder_detent_decoder
  import qedd_pkg::*;
#(
  parameter int NUM_ENCODERS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0] cfg_data
);

  logic                    s1_valid;
  in_t                     s1_data;
  logic [1:0]              last_phase [ENC_SLOTS];
  logic                    phase_seen [ENC_SLOTS];
  logic signed [ACC_W-1:0] step_accum [ENC_SLOTS];
  logic [IDX_W-1:0]        idx;
  logic [1:0]              cur_phase;
  logic [DIV_W-1:0]        divider;
  step_res_t               res;
  logic                    out_free;
  logic                    go;
  logic                    in_take;
  logic                    in_known;

  assign idx       = s1_data.encoder_index;
  assign cur_phase = {s1_data.chan_b, s1_data.chan_a};

  qedd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sel      (idx),
    .divider  (divider)
  );

  qedd_step u_step (
    .seen      (phase_seen[idx]),
    .last_phase(last_phase[idx]),
    .cur_phase (cur_phase),
    .accum     (step_accum[idx]),
    .divider   (divider),
    .res       (res)
  );

  // Flow control: the sample retires unless its tap has nowhere to go
  assign out_free = !out_valid || !out_stall;
  assign go       = s1_valid && (!res.emit || out_free);
  assign in_stall = s1_valid && !go;
  assign in_take  = in_valid && !in_stall;
  assign in_known = 32'(in_data.encoder_index) < NUM_ENCODERS;

  // Sample register; out-of-range encoders are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= in_known;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  // Per-encoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENC_SLOTS; k++) begin
        last_phase[k] <= '0;
        phase_seen[k] <= 1'b0;
        step_accum[k] <= '0;
      end
    end else if (go) begin
      last_phase[idx] <= cur_phase;
      phase_seen[idx] <= 1'b1;
      step_accum[idx] <= res.accum_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.emit) begin
      out_data.tap_encoder   <= idx;
      out_data.tap_direction <= res.dir;
    end
  end

endmodule

// ===== rtl/core/qedd_checker.sv =====
// Port-level checks for the quadrature encoder detent decoder, bound to the top level.
// Depends on qedd_pkg and quadrature_encoder_detent_decoder.
`timescale 1ns / 1ps

module qedd_checker
  import qedd_pkg::*;
#(
  parameter int NUM_ENCODERS = 4
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A held output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // A held input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Input back-pressure only comes from a held output transaction
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  // Taps only name configured encoders
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.tap_encoder) < NUM_ENCODERS)
    else $error("tap from encoder out of range");

endmodule

bind quadrature_encoder_detent_decoder qedd_checker #(
  .NUM_ENCODERS(NUM_ENCODERS)
) u_qedd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/tb.sv =====
// Self-checking testbench for quadrature_encoder_detent_decoder.
// Depends on qedd_pkg and the RTL only. Samples are driven with random gaps and the
// taps are checked against a built-in predictor of the detent counting.
`timescale 1ns / 1ps

module tb;
  import qedd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RAND_ROUNDS    = 6;
  localparam int ROUND_SAMPLES  = 235;

  localparam logic [IDX_W-1:0] REG_DIV_ENC0 = 2'd0;

  localparam int SPIN_FWD = 1;
  localparam int SPIN_REV = -1;

  // Predicts taps from accepted samples and checks them in order
  class tap_scoreboard;
    logic [DIV_W-1:0] divider [ENC_SLOTS];
    logic [1:0]       prev_phase [ENC_SLOTS];
    bit               primed [ENC_SLOTS];
    int               detent_count [ENC_SLOTS];
    out_t             taps_due [$];
    int               errors;

    function new();
      for (int i = 0; i < ENC_SLOTS; i++) begin
        divider[i]      = DIV_RESET;
        prev_phase[i]   = 2'd0;
        primed[i]       = 1'b0;
        detent_count[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_divider(int enc, logic [DIV_W-1:0] value);
      divider[enc] = value;
    endfunction

    // Position of a phase along the forward rotation 0 -> 2 -> 3 -> 1
    function int ring_pos(logic [1:0] ph);
      case (ph)
        2'd0: return 0;
        2'd2: return 1;
        2'd3: return 2;
        default: return 3;
      endcase
    endfunction

    function int phase_delta(logic [1:0] from_ph, logic [1:0] to_ph);
      int d;
      d = (ring_pos(to_ph) - ring_pos(from_ph) + 4) % 4;
      if (d == 1) return 1;
      if (d == 3) return -1;
      return 0;
    endfunction

    // Accepted sample: update encoder state, queue a tap if a detent completes
    function void note_sample(in_t s);
      int         enc;
      int         dv;
      int         cnt;
      int         d;
      logic [1:0] cur;
      out_t       tap;
      enc = s.encoder_index;
      cur = {s.chan_b, s.chan_a};
      if (enc >= ENC_SLOTS) return;
      if (!primed[enc]) begin
        primed[enc]       = 1'b1;
        prev_phase[enc]   = cur;
        detent_count[enc] = 0;
        return;
      end
      d = phase_delta(prev_phase[enc], cur);
      prev_phase[enc] = cur;
      dv = (divider[enc] == 0) ? 1 : int'(divider[enc]);
      cnt = detent_count[enc];
      // reversal restarts the count
      if ((d > 0 && cnt < 0) || (d < 0 && cnt > 0)) cnt = 0;
      cnt += d;
      tap.tap_encoder = enc[IDX_W-1:0];
      if (cnt >= dv) begin
        cnt -= dv;
        if (cnt >= dv) cnt = dv - 1;   // excess after a divider drop is discarded
        tap.tap_direction = DIR_POS;
        taps_due.push_back(tap);
      end else if (cnt <= -dv) begin
        cnt += dv;
        if (cnt <= -dv) cnt = 1 - dv;
        tap.tap_direction = DIR_NEG;
        taps_due.push_back(tap);
      end
      detent_count[enc] = cnt;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_tap(out_t got);
      out_t want;
      if (taps_due.size() == 0) begin
        report_mismatch($sformatf("unexpected tap enc %0d dir %0d",
                                  got.tap_encoder, got.tap_direction));
        return;
      end
      want = taps_due.pop_front();
      if (got.tap_encoder !== want.tap_encoder)
        report_mismatch($sformatf("tap_encoder got %0d want %0d",
                                  got.tap_encoder, want.tap_encoder));
      if (got.tap_direction !== want.tap_direction)
        report_mismatch($sformatf("tap_direction got %0d want %0d (enc %0d)",
                                  got.tap_direction, want.tap_direction, want.tap_encoder));
    endtask

    function int pending();
      return taps_due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [DIV_W-1:0] cfg_data;

  tap_scoreboard sb = new();

  logic [1:0] ph_now [ENC_SLOTS];
  int         spin [ENC_SLOTS];
  bit         tx_calm;
  bit         rx_calm;
  int         idle_cycles;

  logic [DIV_W-1:0] div_plan [RAND_ROUNDS][ENC_SLOTS] = '{
    '{8'd1,   8'd2, 8'd3,   8'd4},
    '{8'd0,   8'd1, 8'd255, 8'd2},
    '{8'd5,   8'd6, 8'd7,   8'd8},
    '{8'd2,   8'd2, 8'd1,   8'd3},
    '{8'd255, 8'd3, 8'd1,   8'd0},
    '{8'd4,   8'd4, 8'd4,   8'd4}
  };

  quadrature_encoder_detent_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Output monitor: every accepted tap goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_tap(out_data);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver back-pressure: short stalls mostly, a few long ones
  initial begin
    int run_len;
    int hold_len;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      if (rx_calm) hold_len = 0;
      else if ($urandom_range(0, 99) < 85) hold_len = $urandom_range(1, 3);
      else hold_len = $urandom_range(15, 60);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [1:0] next_phase(logic [1:0] ph, int dir);
    if (dir > 0) begin
      case (ph)
        2'd0: return 2'd2;
        2'd2: return 2'd3;
        2'd3: return 2'd1;
        default: return 2'd0;
      endcase
    end else begin
      case (ph)
        2'd0: return 2'd1;
        2'd1: return 2'd3;
        2'd3: return 2'd2;
        default: return 2'd0;
      endcase
    end
  endfunction

  // One sample transaction, then a random gap; valid stays high if no gap
  task automatic push_sample(int enc, logic [1:0] ph);
    in_t s;
    int  gap;
    int  r;
    s.encoder_index = enc[IDX_W-1:0];
    s.chan_a        = ph[0];
    s.chan_b        = ph[1];
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic place(int enc, logic [1:0] ph);
    ph_now[enc] = ph;
    push_sample(enc, ph);
  endtask

  task automatic turn(int enc, int dir, int steps);
    repeat (steps) begin
      ph_now[enc] = next_phase(ph_now[enc], dir);
      push_sample(enc, ph_now[enc]);
    end
  endtask

  // Stop sending and let every predicted tap come out
  task automatic wait_taps_done();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dividers(logic [DIV_W-1:0] d0, logic [DIV_W-1:0] d1,
                              logic [DIV_W-1:0] d2, logic [DIV_W-1:0] d3);
    logic [DIV_W-1:0] vals [ENC_SLOTS];
    vals = '{d0, d1, d2, d3};
    for (int i = 0; i < ENC_SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_DIV_ENC0 + i[IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_divider(i, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly clean rotation with occasional reversals, holds and phase jumps
  task automatic random_sample();
    int         enc;
    int         r;
    logic [1:0] ph;
    enc = $urandom_range(0, ENC_SLOTS - 1);
    r   = $urandom_range(0, 99);
    if (r < 8) spin[enc] = -spin[enc];
    if (r < 75) ph = next_phase(ph_now[enc], spin[enc]);
    else if (r < 88) ph = ph_now[enc];
    else ph = 2'($urandom_range(0, 3));
    place(enc, ph);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    for (int i = 0; i < ENC_SLOTS; i++) begin
      ph_now[i] = 2'd0;
      spin[i]   = SPIN_FWD;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset dividers, first sample, full detent, reversal, bad jump, hold
    place(0, 2'd0);
    turn(0, SPIN_FWD, 5);
    turn(0, SPIN_REV, 2);
    place(0, ph_now[0] ^ 2'b11);
    place(0, ph_now[0]);
    place(1, 2'd3);
    turn(1, SPIN_FWD, 3);
    place(2, 2'd1);
    turn(2, SPIN_REV, 3);
    place(3, 2'd2);
    wait_taps_done();

    // Divider drops below pending counts: taps fire even with no movement
    set_dividers(8'd255, 8'd1, 8'd0, 8'd2);
    place(1, ph_now[1]);
    place(2, ph_now[2]);
    turn(1, SPIN_FWD, 1);
    turn(3, SPIN_REV, 2);
    turn(0, SPIN_FWD, 1);
    wait_taps_done();

    // Random rounds, each with its own divider setting
    for (int p = 0; p < RAND_ROUNDS; p++) begin
      if (p == RAND_ROUNDS - 1) begin
        for (int i = 0; i < ENC_SLOTS; i++) div_plan[p][i] = DIV_W'($urandom_range(1, 8));
      end
      set_dividers(div_plan[p][0], div_plan[p][1], div_plan[p][2], div_plan[p][3]);
      for (int k = 0; k < ROUND_SAMPLES; k++) begin
        tx_calm = (k >= 80 && k < 120);
        rx_calm = (k >= 80 && k < 120);
        if (p == 2 && k == 150) wait_taps_done();
        random_sample();
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      wait_taps_done();
    end

    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qedd_pkg.sv
rtl/core/qedd_cfg.sv
rtl/core/qedd_step.sv
rtl/core/quadrature_encoder_detent_decoder.sv
rtl/core/qedd_checker.sv
tb/tb.sv
